// ----- rtl/core/pdrc_pkg.sv -----
// Package: shared types and constants of the PLL divider register calculator.
`default_nettype none
package pdrc_pkg;
  localparam int NUM_WORDS = 5;
  localparam int LADDER_ROWS = 19;

  localparam logic [2:0] CFG_REF = 3'd0;
  localparam logic [2:0] CFG_MAX = 3'd1;
  localparam logic [2:0] CFG_MIN = 3'd2;
  localparam logic [2:0] CFG_MAX_OFS = 3'd3;
  localparam logic [2:0] CFG_MIN_OFS = 3'd4;

  typedef struct packed {
    logic [31:0] above;
    logic [8:0]  mult;
    logic [2:0]  mclk;
    logic [2:0]  bclk;
    logic        pre;
  } ladder_row_t;

  // front to back: one classified request
  typedef struct packed {
    logic        recompute;
    logic        write_all;
    logic [31:0] freq;
  } job_t;

  function automatic ladder_row_t ladder_row(input logic [4:0] idx);
    ladder_row_t r;
    unique case (idx)
      5'd0:  r = '{32'd18000000, 9'd1,   3'd0, 3'd0, 1'b0};
      5'd1:  r = '{32'd9000000,  9'd2,   3'd2, 3'd0, 1'b0};
      5'd2:  r = '{32'd6000000,  9'd3,   3'd3, 3'd0, 1'b0};
      5'd3:  r = '{32'd4500000,  9'd4,   3'd4, 3'd0, 1'b0};
      5'd4:  r = '{32'd3000000,  9'd6,   3'd5, 3'd0, 1'b0};
      5'd5:  r = '{32'd2250000,  9'd8,   3'd6, 3'd0, 1'b0};
      5'd6:  r = '{32'd1500000,  9'd12,  3'd7, 3'd0, 1'b0};
      5'd7:  r = '{32'd1125000,  9'd16,  3'd6, 3'd1, 1'b0};
      5'd8:  r = '{32'd750000,   9'd24,  3'd7, 3'd1, 1'b0};
      5'd9:  r = '{32'd562500,   9'd32,  3'd6, 3'd2, 1'b0};
      5'd10: r = '{32'd375000,   9'd48,  3'd7, 3'd2, 1'b0};
      5'd11: r = '{32'd281250,   9'd64,  3'd6, 3'd3, 1'b0};
      5'd12: r = '{32'd187500,   9'd96,  3'd7, 3'd3, 1'b0};
      5'd13: r = '{32'd140625,   9'd128, 3'd4, 3'd5, 1'b0};
      5'd14: r = '{32'd93750,    9'd192, 3'd5, 3'd5, 1'b0};
      5'd15: r = '{32'd70313,    9'd128, 3'd6, 3'd4, 1'b1};
      5'd16: r = '{32'd46875,    9'd192, 3'd7, 3'd4, 1'b1};
      5'd17: r = '{32'd35156,    9'd256, 3'd6, 3'd5, 1'b1};
      default: r = '{32'd0,      9'd384, 3'd7, 3'd5, 1'b1};
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/pll_divider_register_calc.sv -----
// Top level: PLL divider register calculator.
// Flow: a popped job with a new target goes through the ladder search, scaling, the serial N divide,
// K setup, the serial K divide and the emission of its 5 word slots; an unchanged target goes straight
// to emission, which output stalls hold. A request costs one such
// back-end pass; a two-entry job queue lets the front accept while the back works.
// Synchronous active-low reset restores default config, target 0, shadow words.
`default_nettype none
module pll_divider_register_calc (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_target_hz,
  input  wire logic        in_write_all,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_reg_word,
  output logic             out_last_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [25:0] ref_r;
  logic [31:0] max_r, min_r;
  logic [20:0] maxo_r, mino_r;
  logic job_valid, job_pop;
  pdrc_pkg::job_t job;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= 26'd12000000;
      max_r <= 32'd40000000;
      min_r <= 32'd20000;
      maxo_r <= '0;
      mino_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pdrc_pkg::CFG_REF:     ref_r <= cfg_data[25:0];
        pdrc_pkg::CFG_MAX:     max_r <= cfg_data;
        pdrc_pkg::CFG_MIN:     min_r <= cfg_data;
        pdrc_pkg::CFG_MAX_OFS: maxo_r <= cfg_data[20:0];
        pdrc_pkg::CFG_MIN_OFS: mino_r <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  pdrc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_target_hz, .in_write_all,
    .max_out_hz(max_r), .min_out_hz(min_r),
    .max_offset_hz(maxo_r), .min_offset_hz(mino_r),
    .job_valid, .job_pop, .job
  );

  pdrc_back u_back (
    .clk, .rst_n, .job_valid, .job_pop, .job, .ref_clock_hz(ref_r),
    .out_valid, .out_stall, .out_reg_word, .out_last_word
  );
endmodule
`default_nettype wire

// ----- rtl/core/pdrc_front.sv -----
// Front end: compares, clamps and offsets a request, then queues a job.
`default_nettype none
module pdrc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [31:0]   in_target_hz,
  input  wire logic          in_write_all,
  input  wire logic [31:0]   max_out_hz,
  input  wire logic [31:0]   min_out_hz,
  input  wire logic [20:0]   max_offset_hz,
  input  wire logic [20:0]   min_offset_hz,
  output logic               job_valid,
  input  wire logic          job_pop,
  output pdrc_pkg::job_t     job
);
  logic [31:0] stored_r, stored_nxt;
  pdrc_pkg::job_t q_r [2];
  logic [1:0] cnt_r;
  logic rd_r, wr_r;
  logic push;
  pdrc_pkg::job_t nj;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rd_r];

  always_comb begin
    stored_nxt = stored_r;
    nj.write_all = in_write_all;
    nj.recompute = (in_target_hz != stored_r);
    nj.freq = in_target_hz;
    if (in_target_hz >= max_out_hz) begin
      stored_nxt = max_out_hz;
      nj.freq = max_out_hz + {{11{max_offset_hz[20]}}, max_offset_hz};
    end else if (in_target_hz < min_out_hz) begin
      stored_nxt = min_out_hz;
      nj.freq = min_out_hz + {{11{min_offset_hz[20]}}, min_offset_hz};
    end else begin
      stored_nxt = in_target_hz;
    end
    if (!nj.recompute) stored_nxt = stored_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r <= '0;
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push) begin
        stored_r <= stored_nxt;
        q_r[wr_r] <= nj;
        wr_r <= ~wr_r;
      end
      if (job_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, job_pop};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/pdrc_back.sv -----
// Back end: ladder search, scaling, serial divide, word packing and emission.
`default_nettype none
module pdrc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  output logic               job_pop,
  input  pdrc_pkg::job_t     job,
  input  wire logic [25:0]   ref_clock_hz,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [15:0]        out_reg_word,
  output logic               out_last_word
);
  typedef enum logic [2:0] {S_IDLE, S_LADDER, S_SCALE, S_DIVN, S_KMUL, S_DIVK, S_EMIT}
    state_t;
  state_t state_r;
  logic [4:0] row_r;
  logic [31:0] freq_r;
  logic wall_r;
  pdrc_pkg::ladder_row_t lr;
  logic [25:0] div_r;
  logic [42:0] num_r;       // dividend shifted out MSB first
  logic [42:0] quo_r;
  logic [25:0] rem_r;
  logic [5:0] bit_r;
  logic [3:0] n_r;
  logic [15:0] shadow_r [pdrc_pkg::NUM_WORDS];
  logic [15:0] w_r [pdrc_pkg::NUM_WORDS];
  logic [4:0] emit_r;
  logic [2:0] idx_r;
  logic [26:0] trial;
  logic [25:0] divc;
  logic [49:0] kdiv;
  logic [23:0] k_nxt;
  logic [15:0] nw [pdrc_pkg::NUM_WORDS];

  assign lr = pdrc_pkg::ladder_row(row_r);
  assign trial = {rem_r, num_r[42]} - {1'b0, div_r};
  assign divc = lr.pre ? {1'b0, ref_clock_hz[25:1]} : ref_clock_hz;
  assign job_pop = (state_r == S_IDLE) && job_valid;
  assign out_valid = (state_r == S_EMIT) && emit_r[idx_r];
  assign out_reg_word = w_r[idx_r];
  // remainder times 0xFFFFFF
  assign kdiv = {rem_r, 24'd0} - {24'd0, rem_r};
  assign k_nxt = {quo_r[22:0], !trial[26]};

  always_comb begin
    nw[0] = {8'h0D, lr.mclk, lr.bclk, 2'b01};
    nw[1] = {8'h48, 3'd0, lr.pre, n_r};
    nw[2] = {8'h4A, 2'b00, k_nxt[23:18]};
    nw[3] = {7'd38, k_nxt[17], k_nxt[16:9]};
    nw[4] = {7'd39, k_nxt[8], k_nxt[7:0]};
  end

  always_comb begin
    out_last_word = 1'b1;
    for (int j = 0; j < pdrc_pkg::NUM_WORDS; j++)
      if (3'(j) > idx_r && emit_r[j]) out_last_word = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      shadow_r[0] <= 16'h0D41;
      for (int j = 1; j < pdrc_pkg::NUM_WORDS; j++) shadow_r[j] <= '0;
      idx_r <= '0;
      emit_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (job_valid) begin
          freq_r <= job.freq;
          wall_r <= job.write_all;
          row_r <= '0;
          if (job.recompute) state_r <= S_LADDER;
          else begin
            for (int j = 0; j < pdrc_pkg::NUM_WORDS; j++) w_r[j] <= shadow_r[j];
            emit_r <= {5{job.write_all}};
            idx_r <= '0;
            state_r <= S_EMIT;
          end
        end
        S_LADDER: begin
          if (row_r == 5'(pdrc_pkg::LADDER_ROWS - 1) || freq_r > lr.above)
            state_r <= S_SCALE;
          else row_r <= row_r + 5'd1;
        end
        S_SCALE: begin
          num_r <= {freq_r, 2'b00} * {34'd0, lr.mult};
          div_r <= (divc == '0) ? 26'd1 : divc;
          rem_r <= '0;
          quo_r <= '0;
          bit_r <= 6'd42;
          state_r <= S_DIVN;
        end
        S_DIVN, S_DIVK: begin
          if (!trial[26]) begin
            rem_r <= trial[25:0];
            quo_r <= {quo_r[41:0], 1'b1};
          end else begin
            rem_r <= {rem_r[24:0], num_r[42]};
            quo_r <= {quo_r[41:0], 1'b0};
          end
          num_r <= {num_r[41:0], 1'b0};
          bit_r <= bit_r - 6'd1;
          if (bit_r == '0) state_r <= (state_r == S_DIVN) ? S_KMUL : S_EMIT;
          if (bit_r == '0 && state_r == S_DIVK) idx_r <= '0;
        end
        S_KMUL: begin
          n_r <= quo_r[3:0];
          // upper part of the product is below the divisor: start from it, 24 quotient bits left
          rem_r <= kdiv[49:24];
          num_r <= {kdiv[23:0], 19'd0};
          quo_r <= '0;
          bit_r <= 6'd23;
          state_r <= S_DIVK;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            if (idx_r == 3'(pdrc_pkg::NUM_WORDS - 1)) state_r <= S_IDLE;
            else idx_r <= idx_r + 3'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_DIVK && bit_r == '0) begin
        for (int j = 0; j < pdrc_pkg::NUM_WORDS; j++) begin
          w_r[j] <= nw[j];
          shadow_r[j] <= nw[j];
          emit_r[j] <= wall_r || (nw[j] != shadow_r[j]);
        end
      end
    end
  end
endmodule
`default_nettype wire
